// ----- src/neighbor_mac_cache_macros.svh -----
// Assertion macros used by the neighbor cache controller.
`ifndef NEIGHBOR_MAC_CACHE_MACROS_SVH
`define NEIGHBOR_MAC_CACHE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NMC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define NMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NMC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define NMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- src/nmc_pkg.sv -----
`default_nettype none
package nmc_pkg;
  localparam int BUCKETS   = 256;
  localparam int WAYS      = 5;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int FILL_W    = $clog2(WAYS + 1);
  localparam int ADDR_W    = $clog2(BUCKETS * WAYS);
  localparam int ENTRY_W   = 240;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  MCAST_BYTE = 8'hFF;
  localparam logic [15:0] MCAST_PFX  = 16'h3333;
  localparam logic        CMD_LEARN   = 1'b0;
  localparam logic        CMD_RESOLVE = 1'b1;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic set_bkt;
    logic scan;
    logic chk;
    logic wr;
    logic present;
  } nmc_cmd_t;

  typedef struct packed {
    logic clearing;
    logic hash_last;
    logic resolve;
    logic multicast;
    logic scan_end;
    logic match;
  } nmc_sts_t;
endpackage
`default_nettype wire

// ----- src/nmc_ctrl.sv -----
`default_nettype none
`include "neighbor_mac_cache_macros.svh"
module nmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire nmc_pkg::nmc_sts_t sts,
  output nmc_pkg::nmc_cmd_t      cmd
);
  import nmc_pkg::*;

  typedef enum logic [2:0] {IDLE, HASH, BKT, SCAN, CHK, WR, DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == IDLE) && !sts.clearing;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      IDLE: begin
        cmd.load = in_tvalid && !sts.clearing;
        if (in_tvalid && !sts.clearing) state_nxt = HASH;
      end
      HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_nxt = BKT;
      end
      BKT: begin
        cmd.set_bkt = 1'b1;
        state_nxt = (sts.resolve && sts.multicast) ? DONE : SCAN;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_end) state_nxt = CHK;
        else if (sts.resolve) state_nxt = DONE;
        else state_nxt = WR;
      end
      CHK: begin
        cmd.chk = 1'b1;
        if (!sts.match) state_nxt = SCAN;
        else if (sts.resolve) state_nxt = DONE;
        else state_nxt = WR;
      end
      WR: begin
        cmd.wr = 1'b1;
        state_nxt = DONE;
      end
      DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.present   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NMC_ASSERT_NEXT(a_accept_hash, clk, rst_n, in_tvalid && in_tready, state_r == HASH,
    "accepted beat did not start hashing")
  `NMC_ASSERT_SAME(a_no_resolve_write, clk, rst_n, cmd.wr, !sts.resolve,
    "cache written during a resolve")
  `NMC_ASSERT_NEXT(a_resolve_miss_done, clk, rst_n,
    state_r == SCAN && sts.scan_end && sts.resolve, state_r == DONE,
    "resolve miss did not finish")
endmodule
`default_nettype wire

// ----- src/nmc_dp.sv -----
`default_nettype none
module nmc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_cmd,
  input  wire logic [63:0]       in_ip_high,
  input  wire logic [63:0]       in_ip_low,
  input  wire logic [47:0]       in_new_mac,
  input  wire logic [63:0]       in_timestamp,
  input  wire nmc_pkg::nmc_cmd_t cmd,
  output nmc_pkg::nmc_sts_t      sts,
  output logic                   out_hit,
  output logic [47:0]            out_mac
);
  import nmc_pkg::*;

  logic               cmd_r;
  logic [63:0]        hi_r, lo_r, ts_r;
  logic [47:0]        mac_r;
  logic [31:0]        hash_r;
  logic [3:0]         cnt_r;
  logic [BKT_W-1:0]   bucket_r;
  logic [FILL_W-1:0]  way_r, victim_r;
  logic [63:0]        best_ts_r;
  logic               res_hit_r, out_hit_r;
  logic [47:0]        res_mac_r, out_mac_r;
  logic [FILL_W-1:0]  fill_mem [BUCKETS];
  logic [FILL_W-1:0]  fill_cur_r;
  logic               clr_busy_r;
  logic [BKT_W-1:0]   clr_addr_r;
  logic [ENTRY_W-1:0] mem [BUCKETS * WAYS];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [127:0]       addr_word;
  logic [3:0]         byte_sel;
  logic [7:0]         hbyte;
  logic [31:0]        hash_nxt;
  logic [BKT_W-1:0]   bkt_nxt;
  logic [ADDR_W-1:0]  base, rd_addr, wr_addr;
  logic [63:0]        rd_hi, rd_lo, rd_ts;
  logic [47:0]        rd_mac;

  assign addr_word = {hi_r, lo_r};
  assign byte_sel  = ~cnt_r;
  assign hbyte     = addr_word[{byte_sel, 3'b000} +: 8];
  assign hash_nxt  = (hash_r ^ {24'd0, hbyte}) * FNV_PRIME;
  assign bkt_nxt   = hash_r[15:8] ^ hash_r[7:0];
  assign base      = ADDR_W'(bucket_r) * ADDR_W'(WAYS);
  assign rd_addr   = base + ADDR_W'(way_r);
  assign wr_addr   = base + ADDR_W'(victim_r);
  assign {rd_ts, rd_mac, rd_lo, rd_hi} = rd_data_r;

  assign sts.clearing  = clr_busy_r;
  assign sts.hash_last = (cnt_r == 4'd15);
  assign sts.resolve   = (cmd_r == CMD_RESOLVE);
  assign sts.multicast = (hi_r[63:56] == MCAST_BYTE);
  assign sts.scan_end  = (way_r == fill_cur_r);
  assign sts.match     = (rd_hi == hi_r) && (rd_lo == lo_r);

  assign out_hit = out_hit_r;
  assign out_mac = out_mac_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_cmd;
      hi_r      <= in_ip_high;
      lo_r      <= in_ip_low;
      mac_r     <= in_new_mac;
      ts_r      <= in_timestamp;
      hash_r    <= FNV_BASIS;
      cnt_r     <= '0;
      res_hit_r <= 1'b0;
      res_mac_r <= '0;
    end
    if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_r + 4'd1;
    end
    if (cmd.set_bkt) begin
      bucket_r <= bkt_nxt;
      way_r    <= '0;
      if (sts.resolve && sts.multicast) begin
        res_hit_r <= 1'b1;
        res_mac_r <= {MCAST_PFX, lo_r[31:0]};
      end
    end
    if (cmd.scan && sts.scan_end && fill_cur_r != FILL_W'(WAYS)) victim_r <= fill_cur_r;
    if (cmd.chk) begin
      if (sts.match) begin
        res_hit_r <= 1'b1;
        victim_r  <= way_r;
        if (sts.resolve) res_mac_r <= rd_mac;
      end else begin
        if (way_r == '0 || rd_ts < best_ts_r) begin
          victim_r  <= way_r;
          best_ts_r <= rd_ts;
        end
        way_r <= way_r + FILL_W'(1);
      end
    end
    if (cmd.present) begin
      out_hit_r <= res_hit_r;
      out_mac_r <= res_mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[wr_addr] <= {ts_r, mac_r, lo_r, hi_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + BKT_W'(1);
      if (clr_addr_r == '1) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_bkt) fill_cur_r <= fill_mem[bkt_nxt];
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      fill_mem[clr_addr_r] <= '0;
    end else if (cmd.wr && victim_r == fill_cur_r) begin
      fill_mem[bucket_r] <= fill_cur_r + FILL_W'(1);
    end
  end
endmodule
`default_nettype wire

// ----- src/neighbor_mac_cache.sv -----
// Neighbor cache mapping 128-bit IPv6 addresses to 48-bit MAC addresses.
// Input beats carry a command in in_tuser (0 learn, 1 resolve) and the
// address, MAC and timestamp in in_tdata. Every beat yields one result
// beat: out_tuser is the hit flag and out_tdata the resolved MAC.
// One beat is processed at a time. A beat is hashed one byte per cycle,
// then the bucket's valid ways are read from the entry RAM one way at a
// time, with a write on learn. A multicast resolve skips the RAM and is
// the shortest beat; a learn into a full bucket is the longest.
// Reset starts a pass over every bucket that clears the per-bucket fill
// counts; in_tready stays low until the pass ends and the cache is empty.
// A finished result sits in an output register; if the receiver stalls,
// the next beat is still taken and processed, and waits to be presented
// until the previous result has been taken.
`default_nettype none
module neighbor_mac_cache (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [239:0] in_tdata,  // ip_high, ip_low, new_mac, timestamp
  input  wire logic         in_tuser,  // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata, // mac_out
  output logic              out_tuser  // hit
);
  import nmc_pkg::*;

  nmc_cmd_t cmd;
  nmc_sts_t sts;

  nmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nmc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_tuser),
    .in_ip_high   (in_tdata[63:0]),
    .in_ip_low    (in_tdata[127:64]),
    .in_new_mac   (in_tdata[175:128]),
    .in_timestamp (in_tdata[239:176]),
    .cmd          (cmd),
    .sts          (sts),
    .out_hit      (out_tuser),
    .out_mac      (out_tdata)
  );
endmodule
`default_nettype wire

// ----- dv/tb_neighbor_mac_cache.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_neighbor_mac_cache;
  import nmc_pkg::*;

  localparam int NUM_RANDOM = 930;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac;
  } lookup_t;

  class neighbor_scoreboard;
    logic        valid_q[BUCKETS*WAYS];
    logic [63:0] addr_hi_q[BUCKETS*WAYS];
    logic [63:0] addr_lo_q[BUCKETS*WAYS];
    logic [47:0] mac_q[BUCKETS*WAYS];
    logic [63:0] used_q[BUCKETS*WAYS];
    lookup_t     pending[$];
    int          errors;
    int          learns;
    int          resolves;
    int          hits;

    function void clear();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      errors = 0;
      learns = 0;
      resolves = 0;
      hits = 0;
    endfunction

    function int bucket_index(logic [63:0] hi, logic [63:0] lo);
      logic [31:0]  h;
      logic [127:0] addr;
      h = FNV_BASIS;
      addr = {hi, lo};
      for (int k = 15; k >= 0; k--) begin
        h = (h ^ {24'd0, addr[8*k +: 8]}) * FNV_PRIME;
      end
      return int'((h[15:8] ^ h[7:0]));
    endfunction

    function void note_access(logic cmd, logic [239:0] data);
      logic [63:0] hi, lo, stamp;
      logic [47:0] mac;
      lookup_t     res;
      int          base, victim, e;
      hi = data[63:0];
      lo = data[127:64];
      mac = data[175:128];
      stamp = data[239:176];
      res = '0;
      base = bucket_index(hi, lo) * WAYS;
      if (cmd == CMD_RESOLVE) begin
        resolves++;
        if (hi[63:56] == MCAST_BYTE) begin
          res.hit = 1'b1;
          res.mac = {MCAST_PFX, lo[31:0]};
        end else begin
          for (int w = 0; w < WAYS; w++) begin
            e = base + w;
            if (!valid_q[e]) break;
            if (addr_hi_q[e] == hi && addr_lo_q[e] == lo) begin
              res.hit = 1'b1;
              res.mac = mac_q[e];
              break;
            end
          end
        end
      end else begin
        learns++;
        victim = base;
        for (int w = 0; w < WAYS; w++) begin
          e = base + w;
          if (!valid_q[e]) begin
            victim = e;
            break;
          end
          if (addr_hi_q[e] == hi && addr_lo_q[e] == lo) begin
            res.hit = 1'b1;
            victim = -1;
            mac_q[e] = mac;
            used_q[e] = stamp;
            break;
          end
          if (w > 0 && used_q[e] < used_q[victim]) victim = e;
        end
        if (victim >= 0) begin
          valid_q[victim] = 1'b1;
          addr_hi_q[victim] = hi;
          addr_lo_q[victim] = lo;
          mac_q[victim] = mac;
          used_q[victim] = stamp;
        end
      end
      if (res.hit) hits++;
      pending.push_back(res);
    endfunction

    function void check_result(logic hit, logic [47:0] mac);
      lookup_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result beat: hit=%0b mac=%h", hit, mac);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (hit !== exp_r.hit) begin
        $error("hit mismatch: expected %0b, actual %0b", exp_r.hit, hit);
        errors++;
      end
      if (mac !== exp_r.mac) begin
        $error("mac_out mismatch: expected %h, actual %h", exp_r.mac, mac);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;  // ip_high, ip_low, new_mac, timestamp
  logic         in_tuser;  // command
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata; // mac_out
  logic         out_tuser; // hit

  neighbor_scoreboard sb;
  logic        calm;
  int          idle_cycles;
  logic [63:0] clock_now;
  logic [63:0] known_hi[$];
  logic [63:0] known_lo[$];

  neighbor_mac_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_access(logic cmd, logic [63:0] hi, logic [63:0] lo,
                             logic [47:0] mac, logic [63:0] stamp);
    while (!calm && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {stamp, mac, lo, hi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_LEARN) begin
      known_hi.push_back(hi);
      known_lo.push_back(lo);
    end
  endtask

  // Walks the lower half 1, 2, ... with a fixed upper half and learns the
  // first count addresses that fall into the target bucket.
  task automatic fill_one_bucket(int target, int count, logic [63:0] stamp0);
    logic [63:0] lo;
    int          n;
    n = 0;
    lo = 64'd0;
    while (n < count) begin
      lo++;
      if (sb.bucket_index(64'h2001_0db8_0000_0000, lo) == target) begin
        send_access(CMD_LEARN, 64'h2001_0db8_0000_0000, lo, 48'(rand64()),
                    stamp0 - 64'(n));
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_access(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] hi, lo;
    int          pick, tgt;
    sb = new();
    sb.clear();
    calm = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = CMD_LEARN;
    in_tdata = '0;
    out_tready = 1'b0;
    clock_now = 64'd1000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_access(CMD_RESOLVE, 64'h2001_0000_0000_0001, 64'd1, '0, 64'd0);
    send_access(CMD_LEARN, '0, '0, '0, '0);
    send_access(CMD_LEARN, '1, '1, '1, '1);
    send_access(CMD_RESOLVE, '0, '0, '1, '1);
    send_access(CMD_LEARN, '0, '0, 48'h0123_4567_89ab, 64'd5);
    send_access(CMD_RESOLVE, '0, '0, '0, '0);
    send_access(CMD_RESOLVE, '1, '1, '0, '0);
    send_access(CMD_RESOLVE, 64'hFF02_0000_0000_0000, 64'h0000_0001_FF12_3456, '0, '0);
    send_access(CMD_RESOLVE, 64'hFE80_0000_0000_0000, '1, '0, '0);
    tgt = $urandom_range(BUCKETS - 1);
    fill_one_bucket(tgt, WAYS, 64'hFFFF_FFFF_FFFF_FFF0);
    fill_one_bucket(tgt, 3, 64'd0);
    fill_one_bucket(tgt, WAYS + 2, 64'd77);
    for (int i = 0; i < 4; i++) begin
      send_access(CMD_RESOLVE, known_hi[known_hi.size() - 1 - i],
                  known_lo[known_lo.size() - 1 - i], '0, '0);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 300 && i < 420);
      clock_now += 64'($urandom_range(3));
      pick = $urandom_range(99);
      if (known_hi.size() > 0 && pick < 55) begin
        int k;
        k = $urandom_range(known_hi.size() - 1);
        hi = known_hi[k];
        lo = known_lo[k];
      end else if (pick < 62) begin
        hi = {8'hFF, 56'(rand64())};
        lo = rand64();
      end else begin
        hi = {16'h2001, 40'd0, 8'($urandom_range(3))};
        lo = 64'($urandom_range(700));
        if (pick > 92) begin
          hi = rand64();
          lo = rand64();
        end
      end
      send_access($urandom_range(1) ? CMD_RESOLVE : CMD_LEARN, hi, lo,
                  48'(rand64()), pick > 96 ? rand64() : clock_now);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d learns and %0d resolves, %0d of them hits.",
             sb.learns, sb.resolves, sb.hits);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/nmc_pkg.sv
src/nmc_ctrl.sv
src/nmc_dp.sv
src/neighbor_mac_cache.sv
dv/tb_neighbor_mac_cache.sv
